// ----- hdl/ttd_pkg.sv -----
`timescale 1ns / 1ps

package ttd_pkg;

  // Screen size in pixels
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;

  // Field widths
  localparam int ADC_W  = 10;
  localparam int PRES_W = 11;
  localparam int SX_W   = 9;
  localparam int SY_W   = 8;
  localparam int IDX_W  = 3;

  // Full-scale ADC code
  localparam int ADC_FULL = 1023;

  // Largest product |reading difference| * span sets the divider width
  localparam int SPAN_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int NUM_W    = $clog2(ADC_FULL * SPAN_MAX + 1);
  localparam int CNT_W    = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_START_PRESSURE = 3'd0;
  localparam logic [IDX_W-1:0] REG_STOP_PRESSURE  = 3'd1;
  localparam logic [IDX_W-1:0] REG_X_READING_MIN  = 3'd2;
  localparam logic [IDX_W-1:0] REG_X_READING_MAX  = 3'd3;
  localparam logic [IDX_W-1:0] REG_Y_READING_MIN  = 3'd4;
  localparam logic [IDX_W-1:0] REG_Y_READING_MAX  = 3'd5;
  localparam logic [IDX_W-1:0] REG_FLIPPED        = 3'd6;

  // Calibration reset values
  localparam logic [ADC_W-1:0] X_MIN_RST = 10'd160;
  localparam logic [ADC_W-1:0] X_MAX_RST = 10'd876;
  localparam logic [ADC_W-1:0] Y_MIN_RST = 10'd110;
  localparam logic [ADC_W-1:0] Y_MAX_RST = 10'd892;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [ADC_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// ----- hdl/ttd_div.sv -----
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle
module ttd_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ttd_pkg::div_req_t req,
  output ttd_pkg::div_rsp_t rsp
);

  logic                       run_r;
  logic                       done_r;
  logic [ttd_pkg::CNT_W-1:0]  cnt_r;
  logic [ttd_pkg::ADC_W-1:0]  rem_r;
  logic [ttd_pkg::ADC_W-1:0]  den_r;
  logic [ttd_pkg::NUM_W-1:0]  quo_r;

  logic [ttd_pkg::ADC_W:0]    trial;
  logic [ttd_pkg::ADC_W:0]    diff;
  logic                       ge;
  logic [ttd_pkg::ADC_W-1:0]  rem_nxt;

  // One trial subtract
  assign trial   = {rem_r, quo_r[ttd_pkg::NUM_W-1]};
  assign ge      = (trial >= {1'b0, den_r});
  assign diff    = trial - {1'b0, den_r};
  assign rem_nxt = ge ? diff[ttd_pkg::ADC_W-1:0] : trial[ttd_pkg::ADC_W-1:0];

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= ttd_pkg::CNT_W'(ttd_pkg::NUM_W - 1);
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out of quo_r as quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      den_r <= req.den;
      quo_r <= req.num;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[ttd_pkg::NUM_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ----- hdl/touch_tap_detector.sv -----
`timescale 1ns / 1ps

// Resistive touch panel tap detector.
// in_*  : one beat per panel scan, in_tdata = {z2, z1, y, x} ADC samples.
// out_* : one beat per input beat; out_tuser is the tap flag, out_tdata
//         carries touching, screen_x, screen_y and pressure.
// cfg_* : register writes (thresholds, calibration ends, rotation), always
//         ready; write only while no scan is in flight.
// Pressure runs a touch/release hysteresis; a tap fires on the first scan of
// a new touch, and only then are the readings mapped to pixels and clamped.
// A scan without a tap skips the coordinate maps. A tap runs both coordinate
// maps through one shared serial divider, one quotient bit a cycle; a
// calibration axis of zero width skips its division.
// in_tready is high only while the sequencer is idle, so the next scan is not
// accepted until the last one's result beat is loaded into the output register.
// A finished beat waits in the output register while the receiver stalls;
// the next scan is accepted and worked on meanwhile, and its result holds
// until the register frees.
// Reset clears touch state, output valid and restores register defaults.
module touch_tap_detector (
  input  logic        clk,
  input  logic        rst_n,
  // x[9:0], y[19:10], z1[29:20], z2[39:30]
  input  logic [39:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // touching[0], screen_x[9:1], screen_y[17:10], pressure_value[28:18], zero pad
  output logic [31:0] out_tdata,
  // tap[0]
  output logic        out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int AW = ttd_pkg::ADC_W;
  localparam int NW = ttd_pkg::NUM_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MAP  = 4'b0010,
    S_WAIT = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [ttd_pkg::PRES_W-1:0] start_r, stop_r;
  logic [AW-1:0]              xmin_r, xmax_r, ymin_r, ymax_r;
  logic                       flip_r;

  // Touch state
  logic pressed_r, seen_r;

  // Per-scan working registers
  logic [AW-1:0]              xr_r, yr_r;
  logic [ttd_pkg::PRES_W-1:0] pres_r;
  logic                       tap_r, axis_r, neg_r;
  logic [ttd_pkg::SX_W-1:0]   sx_r;
  logic [ttd_pkg::SY_W-1:0]   sy_r;

  // Output register
  logic        out_valid_r;
  logic        out_tap_r;
  logic [31:0] out_data_r;

  logic in_acc, out_load;

  // Input unpack and pressure
  logic [AW-1:0]              x_adc, y_adc, z1_adc, z2_adc;
  logic [ttd_pkg::PRES_W:0]   pres_w;
  logic [ttd_pkg::PRES_W-1:0] pres;
  logic                       p_set, p_nxt, tap_nxt;

  assign x_adc  = in_tdata[9:0];
  assign y_adc  = in_tdata[19:10];
  assign z1_adc = in_tdata[29:20];
  assign z2_adc = in_tdata[39:30];
  assign pres_w = 12'(ttd_pkg::ADC_FULL) - {2'b00, z2_adc} + {2'b00, z1_adc};
  assign pres   = pres_w[ttd_pkg::PRES_W-1:0];

  // Hysteresis: set test first, then clear test
  assign p_set   = pressed_r | (pres > start_r);
  assign p_nxt   = p_set & ~(pres < stop_r);
  assign tap_nxt = ~seen_r & p_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;

  // Map operands for the current axis
  logic [AW-1:0] mv, ma, mb;
  logic [NW-1:0] span;
  logic [AW:0]   mdiff, mden, mdiff_neg;
  logic [AW-1:0] diff_mag, den_mag, den_neg;
  logic [NW-1:0] num_mag;
  logic          den_zero;

  always_comb begin
    if (!axis_r) begin
      mv   = yr_r;
      ma   = flip_r ? xmax_r : ymin_r;
      mb   = flip_r ? xmin_r : ymax_r;
      span = NW'(ttd_pkg::SCREEN_WIDTH);
    end else begin
      mv   = xr_r;
      ma   = flip_r ? ymin_r : xmax_r;
      mb   = flip_r ? ymax_r : xmin_r;
      span = NW'(ttd_pkg::SCREEN_HEIGHT);
    end
  end

  assign mdiff     = {1'b0, mv} - {1'b0, ma};
  assign mden      = {1'b0, mb} - {1'b0, ma};
  assign mdiff_neg = -mdiff;
  assign diff_mag  = mdiff[AW] ? mdiff_neg[AW-1:0] : mdiff[AW-1:0];
  assign den_neg   = AW'(-mden);
  assign den_mag   = mden[AW] ? den_neg : mden[AW-1:0];
  assign den_zero  = (mden == '0);
  assign num_mag   = NW'(diff_mag) * span;

  // Shared divider
  ttd_pkg::div_req_t div_req;
  ttd_pkg::div_rsp_t div_rsp;

  assign div_req.start = (state_r == S_MAP) & ~den_zero;
  assign div_req.num   = num_mag;
  assign div_req.den   = den_mag;

  ttd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Clamp: negative quotient to zero, large one to the span
  logic [NW-1:0] clamped, store_val;
  logic          store;

  assign clamped   = neg_r ? '0 : ((div_rsp.quo > span) ? span : div_rsp.quo);
  assign store     = ((state_r == S_MAP) & den_zero) | ((state_r == S_WAIT) & div_rsp.done);
  assign store_val = (state_r == S_MAP) ? '0 : clamped;
  assign out_load  = (state_r == S_DONE) & (~out_valid_r | out_tready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = tap_nxt ? S_MAP : S_DONE;
      S_MAP:  if (!den_zero) state_nxt = S_WAIT;
              else if (axis_r) state_nxt = S_DONE;
      S_WAIT: if (div_rsp.done) state_nxt = axis_r ? S_DONE : S_MAP;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pressed_r   <= 1'b0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
      start_r     <= '0;
      stop_r      <= '0;
      xmin_r      <= ttd_pkg::X_MIN_RST;
      xmax_r      <= ttd_pkg::X_MAX_RST;
      ymin_r      <= ttd_pkg::Y_MIN_RST;
      ymax_r      <= ttd_pkg::Y_MAX_RST;
      flip_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        pressed_r <= p_nxt;
        seen_r    <= p_nxt;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      // Register writes; unknown indexes are dropped
      if (cfg_valid) begin
        unique case (cfg_index)
          ttd_pkg::REG_START_PRESSURE: start_r <= cfg_data;
          ttd_pkg::REG_STOP_PRESSURE:  stop_r  <= cfg_data;
          ttd_pkg::REG_X_READING_MIN:  xmin_r  <= cfg_data[AW-1:0];
          ttd_pkg::REG_X_READING_MAX:  xmax_r  <= cfg_data[AW-1:0];
          ttd_pkg::REG_Y_READING_MIN:  ymin_r  <= cfg_data[AW-1:0];
          ttd_pkg::REG_Y_READING_MAX:  ymax_r  <= cfg_data[AW-1:0];
          ttd_pkg::REG_FLIPPED:        flip_r  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      xr_r   <= ~x_adc;
      yr_r   <= ~y_adc;
      pres_r <= pres;
      tap_r  <= tap_nxt;
      axis_r <= 1'b0;
      sx_r   <= '0;
      sy_r   <= '0;
    end else begin
      if (div_req.start) neg_r <= mdiff[AW] ^ mden[AW];
      if (store) begin
        if (!axis_r) sx_r <= store_val[ttd_pkg::SX_W-1:0];
        else         sy_r <= store_val[ttd_pkg::SY_W-1:0];
        axis_r <= 1'b1;
      end
    end
  end

  // Output beat
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tap_r  <= tap_r;
      out_data_r <= {3'b000, pres_r, sy_r, sx_r, pressed_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_tap_r;
  assign out_tdata  = out_data_r;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  a_tap_touching: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[0])
    else $error("tap reported while not touching");

  a_no_tap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[17:1] == 17'd0)
    else $error("coordinates nonzero without tap");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> state_r == S_MAP)
    else $error("divider started outside map step");

endmodule
